// ----- rtl/line_segment_rect_clipper_unit_defines.svh -----
// Assertion helpers shared by the clipper RTL.
// Each expects signals named clk and arst_n in the calling scope.
`ifndef LINE_SEGMENT_RECT_CLIPPER_UNIT_DEFINES_SVH
`define LINE_SEGMENT_RECT_CLIPPER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LSRC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LSRC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lsrc_pkg.sv -----
package lsrc_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS = 4;
	localparam int DIM_BITS = 13;
	localparam int CFG_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
	// room for clip_left plus width * ONE, signed
	localparam int EDGE_BITS =
		((COORD_BITS - 1 > DIM_BITS + FRAC_BITS) ? COORD_BITS - 1 : DIM_BITS + FRAC_BITS) + 2;
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = 2 * COORD_BITS;
	localparam int DIV_CNT_BITS = $clog2(COORD_BITS);
	localparam int MAX_CLIP_STEPS = 8;
	localparam int STEP_BITS = $clog2(MAX_CLIP_STEPS + 1);

	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_BOTTOM = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_WIDTH = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_HEIGHT = 2'd3;

	localparam logic [DIM_BITS-1:0] CLIP_DIM_RESET = 13'd1024;
	localparam logic signed [EDGE_BITS-1:0] EDGE_ONE = EDGE_BITS'(1) << FRAC_BITS;

	typedef logic [3:0] outcode_t;
	localparam outcode_t OC_LEFT = 4'b0001;
	localparam outcode_t OC_RIGHT = 4'b0010;
	localparam outcode_t OC_BOTTOM = 4'b0100;
	localparam outcode_t OC_TOP = 4'b1000;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EDGE_BITS-1:0] edge_t;
	typedef logic signed [DIFF_BITS-1:0] diff_t;
	typedef logic [COORD_BITS-1:0] mag_t;
	typedef logic [DIM_BITS-1:0] dim_t;

	typedef struct packed {
		logic load_in;
		logic select;
		logic prep;
		logic mul;
		logic div_step;
		logic update;
		logic load_out;
		logic visible;
	} cmd_t;

	typedef struct packed {
		outcode_t code_b;
		outcode_t code_e;
		logic den_zero;
	} stat_t;

endpackage

// ----- rtl/lsrc_in_if.sv -----
interface lsrc_in_if;
	import lsrc_pkg::*;

	logic valid;
	logic ready;
	coord_t begin_x;
	coord_t begin_y;
	coord_t end_x;
	coord_t end_y;

	modport source(output valid, begin_x, begin_y, end_x, end_y, input ready);
	modport sink(input valid, begin_x, begin_y, end_x, end_y, output ready);
endinterface

// ----- rtl/lsrc_out_if.sv -----
interface lsrc_out_if;
	import lsrc_pkg::*;

	logic valid;
	logic ready;
	logic visible;
	coord_t out_begin_x;
	coord_t out_begin_y;
	coord_t out_end_x;
	coord_t out_end_y;

	modport source(output valid, visible, out_begin_x, out_begin_y, out_end_x, out_end_y,
		input ready);
	modport sink(input valid, visible, out_begin_x, out_begin_y, out_end_x, out_end_y,
		output ready);
endinterface

// ----- rtl/lsrc_dp.sv -----
module lsrc_dp (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [lsrc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input logic [lsrc_pkg::CFG_BITS-1:0] cfg_data,
	input lsrc_pkg::coord_t in_bx,
	input lsrc_pkg::coord_t in_by,
	input lsrc_pkg::coord_t in_ex,
	input lsrc_pkg::coord_t in_ey,
	input lsrc_pkg::cmd_t cmd,
	output lsrc_pkg::stat_t stat,
	output logic out_vis,
	output lsrc_pkg::coord_t out_bx,
	output lsrc_pkg::coord_t out_by,
	output lsrc_pkg::coord_t out_ex,
	output lsrc_pkg::coord_t out_ey
);
	import lsrc_pkg::*;

	function automatic outcode_t outcode(coord_t x, coord_t y, edge_t xmn, edge_t xmx,
		edge_t ymn, edge_t ymx);
		edge_t xe;
		edge_t ye;
		outcode_t c;
		xe = edge_t'(x);
		ye = edge_t'(y);
		c = '0;
		if (xe < xmn) c = c | OC_LEFT;
		else if (xe > xmx) c = c | OC_RIGHT;
		if (ye < ymn) c = c | OC_BOTTOM;
		else if (ye > ymx) c = c | OC_TOP;
		return c;
	endfunction

	function automatic mag_t magn(diff_t v);
		diff_t a;
		a = (v < 0) ? -v : v;
		return a[COORD_BITS-1:0];
	endfunction

	coord_t clip_left_q, clip_bottom_q;
	dim_t clip_width_q, clip_height_q;

	edge_t xmn_q, xmx_q, ymn_q, ymx_q;
	coord_t bx_q, by_q, ex_q, ey_q;

	// select stage
	logic ymode_q, first_q;
	edge_t edge_q;
	coord_t a0_q, a1_q, f0_q, f1_q;

	// prep stage
	coord_t ec_q;
	mag_t den_q, dmag_q, tmag_q;
	logic dneg_q, den_zero_q;

	// divider
	mag_t rem_q, low_q;

	logic out_vis_q;
	coord_t obx_q, oby_q, oex_q, oey_q;

	outcode_t code_b, code_e, co;
	logic co_y;
	edge_t edge_sel;
	coord_t lo, hi, ec;
	diff_t da, dd, dt;
	logic [PROD_BITS-1:0] prod;
	logic [COORD_BITS:0] trial;
	logic trial_ge;
	logic round_up;
	logic [COORD_BITS:0] q_rnd;
	logic signed [DIFF_BITS:0] res_w;
	coord_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q <= '0;
			clip_bottom_q <= '0;
			clip_width_q <= CLIP_DIM_RESET;
			clip_height_q <= CLIP_DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_CLIP_LEFT: clip_left_q <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data[COORD_BITS-1:0];
				REG_CLIP_WIDTH: clip_width_q <= cfg_data[DIM_BITS-1:0];
				REG_CLIP_HEIGHT: clip_height_q <= cfg_data[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		code_b = outcode(bx_q, by_q, xmn_q, xmx_q, ymn_q, ymx_q);
		code_e = outcode(ex_q, ey_q, xmn_q, xmx_q, ymn_q, ymx_q);
		co = (code_b != '0) ? code_b : code_e;
		co_y = ((co & (OC_TOP | OC_BOTTOM)) != '0);
		if ((co & OC_TOP) != '0) edge_sel = ymx_q;
		else if ((co & OC_BOTTOM) != '0) edge_sel = ymn_q;
		else if ((co & OC_RIGHT) != '0) edge_sel = xmx_q;
		else edge_sel = xmn_q;
	end

	always_comb begin
		lo = (a0_q < a1_q) ? a0_q : a1_q;
		hi = (a0_q < a1_q) ? a1_q : a0_q;
		if (edge_q < edge_t'(lo)) ec = lo;
		else if (edge_q > edge_t'(hi)) ec = hi;
		else ec = edge_q[COORD_BITS-1:0];
		da = diff_t'(a1_q) - diff_t'(a0_q);
		dd = diff_t'(f1_q) - diff_t'(f0_q);
		dt = diff_t'(ec) - diff_t'(a0_q);
	end

	always_comb begin
		prod = PROD_BITS'(dmag_q) * PROD_BITS'(tmag_q);
		trial = {rem_q, low_q[COORD_BITS-1]};
		trial_ge = (trial >= {1'b0, den_q});
		round_up = ({rem_q, 1'b0} >= {1'b0, den_q});
		q_rnd = {1'b0, low_q} + (COORD_BITS + 1)'(round_up);
		if (dneg_q) res_w = (DIFF_BITS + 1)'(f0_q) - $signed({1'b0, q_rnd});
		else res_w = (DIFF_BITS + 1)'(f0_q) + $signed({1'b0, q_rnd});
		res = res_w[COORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			bx_q <= in_bx;
			by_q <= in_by;
			ex_q <= in_ex;
			ey_q <= in_ey;
			xmn_q <= edge_t'(clip_left_q);
			ymn_q <= edge_t'(clip_bottom_q);
			xmx_q <= edge_t'(clip_left_q) + (edge_t'(clip_width_q) <<< FRAC_BITS) - EDGE_ONE;
			ymx_q <= edge_t'(clip_bottom_q) + (edge_t'(clip_height_q) <<< FRAC_BITS) - EDGE_ONE;
		end else if (cmd.update) begin
			if (first_q) begin
				bx_q <= ymode_q ? res : ec_q;
				by_q <= ymode_q ? ec_q : res;
			end else begin
				ex_q <= ymode_q ? res : ec_q;
				ey_q <= ymode_q ? ec_q : res;
			end
		end

		if (cmd.select) begin
			ymode_q <= co_y;
			first_q <= (code_b != '0);
			edge_q <= edge_sel;
			a0_q <= co_y ? by_q : bx_q;
			a1_q <= co_y ? ey_q : ex_q;
			f0_q <= co_y ? bx_q : by_q;
			f1_q <= co_y ? ex_q : ey_q;
		end

		if (cmd.prep) begin
			ec_q <= ec;
			den_q <= magn(da);
			dmag_q <= magn(dd);
			tmag_q <= magn(dt);
			dneg_q <= (dd < 0);
			den_zero_q <= (a1_q == a0_q);
		end

		// quotient fits COORD_BITS, so the high half is already below den
		if (cmd.mul) begin
			rem_q <= prod[PROD_BITS-1:COORD_BITS];
			low_q <= prod[COORD_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? COORD_BITS'(trial - {1'b0, den_q}) : trial[COORD_BITS-1:0];
			low_q <= {low_q[COORD_BITS-2:0], trial_ge};
		end

		if (cmd.load_out) begin
			out_vis_q <= cmd.visible;
			obx_q <= bx_q;
			oby_q <= by_q;
			oex_q <= ex_q;
			oey_q <= ey_q;
		end
	end

	assign stat.code_b = code_b;
	assign stat.code_e = code_e;
	assign stat.den_zero = den_zero_q;

	assign out_vis = out_vis_q;
	assign out_bx = obx_q;
	assign out_by = oby_q;
	assign out_ex = oex_q;
	assign out_ey = oey_q;
endmodule

// ----- rtl/lsrc_ctrl.sv -----
`include "line_segment_rect_clipper_unit_defines.svh"

module lsrc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input lsrc_pkg::stat_t stat,
	output lsrc_pkg::cmd_t cmd
);
	import lsrc_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_SEL = 3'd2;
	localparam logic [2:0] S_PREP = 3'd3;
	localparam logic [2:0] S_MUL = 3'd4;
	localparam logic [2:0] S_DIV = 3'd5;
	localparam logic [2:0] S_FIN = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(COORD_BITS - 1);
	localparam logic [STEP_BITS-1:0] STEP_MAX = STEP_BITS'(MAX_CLIP_STEPS);

	logic [2:0] state_q, state_d;
	logic [STEP_BITS-1:0] step_q, step_d;
	logic [DIV_CNT_BITS-1:0] div_cnt_q, div_cnt_d;
	logic vis_q, vis_d;
	logic out_valid_q;
	logic trivial_in, trivial_out;

	assign trivial_in = ((stat.code_b | stat.code_e) == '0);
	assign trivial_out = ((stat.code_b & stat.code_e) != '0) || (step_q >= STEP_MAX);

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		div_cnt_d = div_cnt_q;
		vis_d = vis_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					step_d = '0;
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (trivial_in) begin
					vis_d = 1'b1;
					state_d = S_DONE;
				end else if (trivial_out) begin
					vis_d = 1'b0;
					state_d = S_DONE;
				end else begin
					state_d = S_SEL;
				end
			end
			S_SEL: begin
				cmd.select = 1'b1;
				state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				if (stat.den_zero) begin
					vis_d = 1'b0;
					state_d = S_DONE;
				end else begin
					cmd.mul = 1'b1;
					div_cnt_d = '0;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) state_d = S_FIN;
				else div_cnt_d = div_cnt_q + 1'b1;
			end
			S_FIN: begin
				cmd.update = 1'b1;
				step_d = step_q + 1'b1;
				state_d = S_EVAL;
			end
			S_DONE: begin
				cmd.visible = vis_q;
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			div_cnt_q <= '0;
			vis_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			div_cnt_q <= div_cnt_d;
			vis_q <= vis_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`LSRC_ASSERT_NXT(a_accept_to_eval, in_valid && in_ready, state_q == S_EVAL,
		"accepted item did not start evaluation")
	`LSRC_ASSERT_NXT(a_div_to_fin, (state_q == S_DIV) && (div_cnt_q == DIV_LAST),
		state_q == S_FIN, "divider did not finish after its last step")
	`LSRC_ASSERT_NXT(a_load_out_valid, cmd.load_out, out_valid_q,
		"loaded result not presented")
	`LSRC_ASSERT_IMP(a_step_bound, state_q == S_SEL, step_q < STEP_MAX,
		"clip step started past the step limit")
	`LSRC_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_q || out_ready,
		"pending result overwritten")
endmodule

// ----- rtl/line_segment_rect_clipper_unit.sv -----
// Channel   Dir  Payload
// seg_in    in   begin_x, begin_y, end_x, end_y      (signed Q12.4)
// seg_out   out  visible, out_begin_x/_y, out_end_x/_y (signed Q12.4)
// cfg       in   cfg_we, cfg_idx, cfg_data (left, bottom, width, height)
//
// One segment is in flight at a time. An item runs k clip steps (0..8) from
// acceptance to the output register, and each step uses a 16-bit restoring
// divider.
// The output register lets a new segment be accepted while a result waits.
// arst_n clears control state and loads the reset clip rectangle.
// A stalled seg_out holds the result and the finished segment until taken.
module line_segment_rect_clipper_unit (
	input logic clk,
	input logic arst_n,
	lsrc_in_if.sink seg_in,
	lsrc_out_if.source seg_out,
	input logic cfg_we,
	input logic [lsrc_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input logic [lsrc_pkg::CFG_BITS-1:0] cfg_data
);
	import lsrc_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	stat_t stat;

	// Sequencer: evaluate outcodes, run one clip step (select edge, prepare
	// operands, multiply, divide, round and move endpoint), repeat, then hand
	// the result to the output register.
	lsrc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(seg_in.valid),
		.in_ready(seg_in.ready),
		.out_valid(seg_out.valid),
		.out_ready(seg_out.ready),
		.stat(stat),
		.cmd(cmd)
	);

	// Datapath: clip registers, endpoints, edge math, multiplier, divider and
	// output register.
	lsrc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_bx(seg_in.begin_x),
		.in_by(seg_in.begin_y),
		.in_ex(seg_in.end_x),
		.in_ey(seg_in.end_y),
		.cmd(cmd),
		.stat(stat),
		.out_vis(seg_out.visible),
		.out_bx(seg_out.out_begin_x),
		.out_by(seg_out.out_begin_y),
		.out_ex(seg_out.out_end_x),
		.out_ey(seg_out.out_end_y)
	);
endmodule
